// ----- hdl/tnb_pkg.sv -----
// ---------------------------------------------------------------------------
// tnb_pkg
// Shared types and constants for the tunable notch biquad.
// ---------------------------------------------------------------------------
package tnb_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 30;
  localparam int CNT_W              = 6;

  localparam logic [31:0] TS_RESET = 32'd429497;
  localparam logic [31:0] WB_RESET = 32'd16085;
  localparam logic [31:0] W0_RESET = 32'd80425;

  localparam logic [1:0] REG_TS = 2'd0;
  localparam logic [1:0] REG_WB = 2'd1;
  localparam logic [1:0] REG_W0 = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_RETUNE = 1'b1;

  localparam logic [1:0] COEF_B   = 2'd0;
  localparam logic [1:0] COEF_MID = 2'd1;
  localparam logic [1:0] COEF_A2  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RT0, ST_RT1, ST_RT2, ST_RT3,
    ST_DLOAD, ST_DSTEP, ST_DFIN, ST_MAC, ST_ROUND, ST_OUT
  } tnb_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LD_SAMPLE, OP_LD_FREQ, OP_RT0, OP_RT1, OP_RT2, OP_RT3,
    OP_DLOAD, OP_DSTEP, OP_DFIN, OP_MAC, OP_ROUND, OP_OUT
  } tnb_op_t;

  typedef struct packed {
    tnb_op_t          op;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       kidx;
  } tnb_cmd_t;

  typedef struct packed {
    logic out_busy;
  } tnb_stat_t;

endpackage

// ----- hdl/tunable_notch_biquad.sv -----
// ---------------------------------------------------------------------------
// tunable_notch_biquad
// Second-order notch filter, direct form I, bilinear-transform coefficients.
// ---------------------------------------------------------------------------
// Input beats carry kind, sample and new_freq on a valid/ready channel. A
// sample beat gives one output beat (filtered, clipped); a retune beat
// loads a new centre frequency and gives none.
// A sample runs from accept through the MAC steps on the shared 33x33
// multiplier and accumulator, a rounding step (ST_ROUND) and a saturation
// step (ST_OUT). in_ready is high again as out_valid rises.
// A retune runs ST_RT0 to ST_RT3, then the restoring divider for each of
// the three coefficients, producing one quotient bit per cycle.
// Registers on the APB port (0 sample_period, 4 notch_bandwidth,
// 8 initial_notch_freq) trigger the same recompute when written.
// After reset the block computes the reset coefficients first
// with in_ready low. A stalled receiver holds the result in the output
// register; the next sample is still accepted and waits before its
// output cycle until the register frees.
// ---------------------------------------------------------------------------
module tunable_notch_biquad import tnb_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic [31:0]                    in_new_freq,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered,
  output logic                           out_clipped,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [31:0] ts_r, wb_r, w0_r;
  logic        wr;
  logic [1:0]  widx;
  logic        restart;
  tnb_cmd_t    cmd;
  tnb_stat_t   stat;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign widx    = paddr[3:2];
  assign restart = wr && (widx == REG_TS || widx == REG_WB || widx == REG_W0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= TS_RESET;
      wb_r <= WB_RESET;
      w0_r <= W0_RESET;
    end else if (wr) begin
      priority case (widx)
        REG_TS:  ts_r <= pwdata;
        REG_WB:  wb_r <= pwdata;
        REG_W0:  w0_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority case (widx)
      REG_TS:  prdata = ts_r;
      REG_WB:  prdata = wb_r;
      REG_W0:  prdata = w0_r;
      default: prdata = '0;
    endcase
  end

  tnb_ctrl #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .restart  (restart),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tnb_datapath #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .ts           (ts_r),
    .wb           (wb_r),
    .cur_ld       (wr && widx == REG_W0),
    .cur_val      (pwdata),
    .in_sample    (in_sample),
    .in_new_freq  (in_new_freq),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_filtered (out_filtered),
    .out_clipped  (out_clipped)
  );

endmodule

// ----- hdl/tnb_ctrl.sv -----
// ---------------------------------------------------------------------------
// tnb_ctrl
// Sequencer for coefficient recompute, long division and the filter macs.
// ---------------------------------------------------------------------------
module tnb_ctrl import tnb_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_kind,
  input  logic      restart,
  input  tnb_stat_t stat,
  output logic      in_ready,
  output tnb_cmd_t  cmd
);

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(COEF_FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] LAST_MAC  = CNT_W'(5);

  tnb_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RT0;
      cnt_r   <= '0;
      k_r     <= COEF_B;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.cnt   = cnt_r;
    cmd.kidx  = k_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cnt_nxt = '0;
          if (in_kind == KIND_RETUNE) begin
            cmd.op    = OP_LD_FREQ;
            state_nxt = ST_RT0;
          end else begin
            cmd.op    = OP_LD_SAMPLE;
            state_nxt = ST_MAC;
          end
        end
      end
      ST_RT0: begin
        cmd.op    = OP_RT0;
        state_nxt = ST_RT1;
      end
      ST_RT1: begin
        cmd.op    = OP_RT1;
        state_nxt = ST_RT2;
      end
      ST_RT2: begin
        cmd.op    = OP_RT2;
        state_nxt = ST_RT3;
      end
      ST_RT3: begin
        cmd.op    = OP_RT3;
        k_nxt     = COEF_B;
        state_nxt = ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd.op    = OP_DLOAD;
        cnt_nxt   = '0;
        state_nxt = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.op  = OP_DSTEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) state_nxt = ST_DFIN;
      end
      ST_DFIN: begin
        cmd.op = OP_DFIN;
        if (k_r == COEF_A2) begin
          state_nxt = ST_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_DLOAD;
        end
      end
      ST_MAC: begin
        cmd.op  = OP_MAC;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_MAC) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.op    = OP_ROUND;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (restart) begin
      state_nxt = ST_RT0;
      k_nxt     = COEF_B;
    end
  end

endmodule

// ----- hdl/tnb_datapath.sv -----
// ---------------------------------------------------------------------------
// tnb_datapath
// Shared multiplier, restoring divider, accumulator and filter history.
// ---------------------------------------------------------------------------
module tnb_datapath import tnb_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tnb_cmd_t                       cmd,
  output tnb_stat_t                      stat,
  input  logic [31:0]                    ts,
  input  logic [31:0]                    wb,
  input  logic                           cur_ld,
  input  logic [31:0]                    cur_val,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic [31:0]                    in_new_freq,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered,
  output logic                           out_clipped
);

  localparam int QW = COEF_FRAC_BITS + 4;
  localparam logic [63:0]   FOUR_U  = 64'h4_0000_0000;
  localparam logic [63:0]   EIGHT_U = 64'h8_0000_0000;
  localparam logic [QW-1:0] CHI     = QW'((64'd1 << (COEF_FRAC_BITS + 1)) - 64'd1);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [63:0] Y_HI = 64'sh7fff_ffff;
  localparam logic signed [63:0] Y_LO = -64'sh8000_0000;
  localparam logic signed [32:0] S_HI = (33'sd1 <<< (SAMPLE_WIDTH - 1)) - 33'sd1;
  localparam logic signed [32:0] S_LO = -(33'sd1 <<< (SAMPLE_WIDTH - 1));

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  logic [31:0]              cur_r;
  logic signed [31:0]       cb_r, cm_r, ca_r;
  logic signed [SAMPLE_WIDTH-1:0] x0_r, xi0_r, xi1_r;
  logic signed [31:0]       yo0_r, yo1_r;
  logic signed [65:0]       prod_r;
  logic [30:0]              p_r;
  logic [60:0]              q_r;
  logic [61:0]              p2_r;
  logic [63:0]              d0_r;
  logic [64:0]              rem_r;
  logic [QW-1:0]            quo_r;
  logic                     neg_r;
  logic signed [63:0]       acc_r;
  logic                     ov_r;
  logic signed [SAMPLE_WIDTH-1:0] of_r;
  logic                     oc_r;

  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic [63:0] psum, qsum, pos, negv;
  logic [64:0] dv, rs;
  logic        ge, rnd;
  logic [QW-1:0] mag, mcl;
  logic signed [33:0] cval;
  logic signed [63:0] term, ysh, ysat;
  logic signed [32:0] ys;

  assign mp = ma * mb;

  // multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_RT0: begin
        ma = $signed({1'b0, ts});
        mb = $signed({1'b0, cur_r});
      end
      OP_RT1: begin
        ma = $signed({1'b0, ts});
        mb = $signed({1'b0, wb});
      end
      OP_RT2: begin
        ma = $signed({2'b0, p_r});
        mb = $signed({2'b0, p_r});
      end
      OP_MAC: begin
        priority case (cmd.cnt)
          CNT_W'(0): begin ma = 33'(cb_r); mb = 33'(x0_r);  end
          CNT_W'(1): begin ma = 33'(cm_r); mb = 33'(xi0_r); end
          CNT_W'(2): begin ma = 33'(cb_r); mb = 33'(xi1_r); end
          CNT_W'(3): begin ma = 33'(cm_r); mb = 33'(yo0_r); end
          default:   begin ma = 33'(ca_r); mb = 33'(yo1_r); end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    psum = prod_r[63:0] + 64'h80_0000;
    qsum = prod_r[63:0] + 64'd128;
    priority case (cmd.kidx)
      COEF_B: begin
        pos  = {2'b0, p2_r} + FOUR_U;
        negv = '0;
      end
      COEF_MID: begin
        pos  = {1'b0, p2_r, 1'b0};
        negv = EIGHT_U;
      end
      default: begin
        pos  = {2'b0, p2_r} + FOUR_U;
        negv = {2'b0, q_r, 1'b0};
      end
    endcase
    // first step compares against twice the divisor, then plain long division
    dv  = (cmd.cnt == '0) ? {d0_r, 1'b0} : {1'b0, d0_r};
    rs  = (cmd.cnt >= CNT_W'(2)) ? {rem_r[63:0], 1'b0} : rem_r;
    ge  = rs >= dv;
    rnd = {rem_r[63:0], 1'b0} >= {1'b0, d0_r};
    mag = quo_r + QW'(rnd);
    if (neg_r) mcl = (mag > CHI + 1'b1) ? CHI + 1'b1 : mag;
    else       mcl = (mag > CHI) ? CHI : mag;
    cval = neg_r ? -$signed(34'(mcl)) : $signed(34'(mcl));
    term = (cmd.cnt >= CNT_W'(4)) ? -prod_r[63:0] : prod_r[63:0];
    ysh  = acc_r >>> COEF_FRAC_BITS;
    if (ysh > Y_HI)      ysat = Y_HI;
    else if (ysh < Y_LO) ysat = Y_LO;
    else                 ysat = ysh;
    ys = ysat[32:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= W0_RESET;
      xi0_r <= '0;
      xi1_r <= '0;
      yo0_r <= '0;
      yo1_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (cmd.op == OP_LD_FREQ) cur_r <= in_new_freq;
      else if (cur_ld)          cur_r <= cur_val;
      // set by a new result, cleared once the beat is taken
      ov_r <= (cmd.op == OP_OUT) || (ov_r && !out_ready);
      if (cmd.op == OP_OUT) begin
        xi1_r <= xi0_r;
        xi0_r <= x0_r;
        yo1_r <= yo0_r;
        yo0_r <= ysat[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LD_SAMPLE: x0_r <= in_sample;
      OP_RT0: prod_r <= mp;
      OP_RT1: begin
        prod_r <= mp;
        p_r    <= (|psum[63:55]) ? 31'h7fff_ffff : psum[54:24];
      end
      OP_RT2: begin
        prod_r <= mp;
        q_r    <= {5'b0, qsum[63:8]};
      end
      OP_RT3: begin
        p2_r <= prod_r[61:0];
        d0_r <= {2'b0, prod_r[61:0]} + {2'b0, q_r, 1'b0} + FOUR_U;
      end
      OP_DLOAD: begin
        neg_r <= pos < negv;
        rem_r <= {1'b0, (pos >= negv) ? pos - negv : negv - pos};
        quo_r <= '0;
      end
      OP_DSTEP: begin
        rem_r <= ge ? rs - dv : rs;
        quo_r <= {quo_r[QW-2:0], ge};
      end
      OP_DFIN: begin
        priority case (cmd.kidx)
          COEF_B:   cb_r <= cval[31:0];
          COEF_MID: cm_r <= cval[31:0];
          default:  ca_r <= cval[31:0];
        endcase
      end
      OP_MAC: begin
        if (cmd.cnt < CNT_W'(5)) prod_r <= mp;
        if (cmd.cnt == '0) acc_r <= '0;
        else               acc_r <= sat_add(acc_r, term);
      end
      OP_ROUND: acc_r <= sat_add(acc_r, HALF);
      OP_OUT: begin
        if (ys > S_HI) begin
          of_r <= S_HI[SAMPLE_WIDTH-1:0];
          oc_r <= 1'b1;
        end else if (ys < S_LO) begin
          of_r <= S_LO[SAMPLE_WIDTH-1:0];
          oc_r <= 1'b1;
        end else begin
          of_r <= ys[SAMPLE_WIDTH-1:0];
          oc_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign stat.out_busy = ov_r && !out_ready;
  assign out_valid     = ov_r;
  assign out_filtered  = of_r;
  assign out_clipped   = oc_r;

endmodule

// ----- tb/tb_tunable_notch_biquad.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_tunable_notch_biquad
// Self-checking bench for the tunable notch biquad: an in-bench fixed-point
// notch model predicts each filtered sample; retunes, register writes,
// random stalls on both channels and a long output hold-off are exercised.
// ---------------------------------------------------------------------------
module tb_tunable_notch_biquad;
  import tnb_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int FB = COEF_FRAC_BITS_DEF;
  localparam logic [3:0] ADDR_TS = 4'(REG_TS) << 2;
  localparam logic [3:0] ADDR_WB = 4'(REG_WB) << 2;
  localparam logic [3:0] ADDR_W0 = 4'(REG_W0) << 2;
  localparam int SETTLE = 5 + 3 * (FB + 4) + 20;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic                 kind;
    logic signed [SW-1:0] sample;
    logic [31:0]          new_freq;
  } notch_item_t;

  typedef struct {
    logic signed [SW-1:0] filtered;
    logic                 clipped;
  } notch_out_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready, in_kind = 1'b0;
  logic signed [SW-1:0] in_sample = '0;
  logic [31:0] in_new_freq = '0;
  logic out_valid, out_ready = 1'b0, out_clipped;
  logic signed [SW-1:0] out_filtered;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  tunable_notch_biquad uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // notch model state
  logic [31:0] ts_q, wb_q, w0_init, w0_now;
  longint coef_b, coef_m, coef_a;
  longint hist_x [2];
  longint hist_y [2];

  notch_item_t pending_items[$];
  notch_out_t  expected_outs[$];
  int errors = 0, n_samples = 0, n_retunes = 0, n_clipped = 0;
  bit calm = 0;            // no random idling while set
  bit hold_req = 0;        // asks for the long receiver hold-off
  bit hold_on = 0;
  logic in_ready_seen = 1'b0;

  function automatic longint unsigned div_round(longint unsigned num, longint unsigned den);
    longint unsigned quo, rem;
    quo = num / den;
    rem = num % den;
    for (int i = 0; i < FB; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem -= den;
        quo |= 1;
      end
    end
    if ((rem << 1) >= den) quo += 1;
    return quo;
  endfunction

  function automatic longint clamp_coef(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (FB + 1)) - 1;
    lo = -(longint'(1) <<< (FB + 1));
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint signed_ratio(longint unsigned pos, longint unsigned neg,
                                          longint unsigned den);
    if (pos >= neg) return clamp_coef(longint'(div_round(pos - neg, den)));
    return clamp_coef(-longint'(div_round(neg - pos, den)));
  endfunction

  task automatic retune_coefs();
    longint unsigned pr, qr, p, q, p2, d0, one;
    one = 64'd1 << 32;
    pr = longint'(ts_q) * longint'(w0_now);
    qr = longint'(ts_q) * longint'(wb_q);
    p = (pr + (64'd1 << 23)) >> 24;
    q = (qr + 128) >> 8;
    if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
    if (q > (64'd1 << 60)) q = 64'd1 << 60;
    p2 = p * p;
    d0 = p2 + 2 * q + 4 * one;
    coef_b = clamp_coef(longint'(div_round(p2 + 4 * one, d0)));
    coef_m = signed_ratio(2 * p2, 8 * one, d0);
    coef_a = signed_ratio(p2 + 4 * one, 2 * q, d0);
  endtask

  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (b > 0 && s < a) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (b < 0 && s > a) return 64'sh8000_0000_0000_0000;
    return s;
  endfunction

  task automatic predict_notch(notch_item_t it);
    longint x0, acc, y, o;
    notch_out_t r;
    if (it.kind == KIND_RETUNE) begin
      w0_now = it.new_freq;
      retune_coefs();
      n_retunes++;
      return;
    end
    x0 = longint'(it.sample);
    acc = coef_b * x0;
    acc = sat_add(acc, coef_m * hist_x[0]);
    acc = sat_add(acc, coef_b * hist_x[1]);
    acc = sat_add(acc, -(coef_m * hist_y[0]));
    acc = sat_add(acc, -(coef_a * hist_y[1]));
    acc = sat_add(acc, longint'(1) <<< (FB - 1));
    y = acc >>> FB;
    if (y > 64'sh7FFF_FFFF) y = 64'sh7FFF_FFFF;
    if (y < -64'sh8000_0000) y = -64'sh8000_0000;
    o = y;
    r.clipped = 1'b0;
    if (o > (longint'(1) <<< (SW - 1)) - 1) begin
      o = (longint'(1) <<< (SW - 1)) - 1;
      r.clipped = 1'b1;
    end
    if (o < -(longint'(1) <<< (SW - 1))) begin
      o = -(longint'(1) <<< (SW - 1));
      r.clipped = 1'b1;
    end
    r.filtered = o[SW-1:0];
    hist_x[1] = hist_x[0];
    hist_x[0] = x0;
    hist_y[1] = hist_y[0];
    hist_y[0] = y;
    expected_outs.push_back(r);
    n_samples++;
  endtask

  // long receiver hold-off, counted in cycles
  initial begin
    wait (hold_req);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
          in_valid <= 1'b1;
          in_kind <= pending_items[0].kind;
          in_sample <= pending_items[0].sample;
          in_new_freq <= pending_items[0].new_freq;
          void'(pending_items.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_on) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || $urandom_range(99) >= 21;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    in_ready_seen <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready)
      predict_notch('{in_kind, in_sample, in_new_freq});
    if (rst_n && out_valid && out_ready) begin
      if (expected_outs.size() == 0) begin
        $error("unexpected output beat: filtered %0d", out_filtered);
        errors++;
      end else begin
        if (out_filtered !== expected_outs[0].filtered) begin
          $error("filtered: expected %0d, got %0d", expected_outs[0].filtered, out_filtered);
          errors++;
        end
        if (out_clipped !== expected_outs[0].clipped) begin
          $error("clipped: expected %0b, got %0b", expected_outs[0].clipped, out_clipped);
          errors++;
        end
        if (expected_outs[0].clipped) n_clipped++;
        void'(expected_outs.pop_front());
      end
    end
  end

  task automatic reg_write(logic [3:0] addr, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      ADDR_TS: ts_q = val;
      ADDR_WB: wb_q = val;
      default: begin
        w0_init = val;
        w0_now = val;
      end
    endcase
    retune_coefs();
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_outs.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic notch_item_t sample_item(logic signed [SW-1:0] s);
    return '{KIND_SAMPLE, s, 32'($urandom)};
  endfunction

  function automatic notch_item_t retune_item(logic [31:0] f);
    return '{KIND_RETUNE, SW'($urandom), f};
  endfunction

  task automatic random_block(int n, bit big);
    logic signed [SW-1:0] s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0)
        pending_items.push_back(retune_item(
          $urandom_range(3) == 0 ? $urandom : $urandom_range(400000, 20000)));
      else begin
        s = big ? SW'($urandom) : SW'($signed($urandom_range(8000)) - 4000);
        pending_items.push_back(sample_item(s));
      end
    end
  endtask

  initial begin
    ts_q = TS_RESET; wb_q = WB_RESET; w0_init = W0_RESET; w0_now = W0_RESET;
    hist_x = '{0, 0}; hist_y = '{0, 0};
    retune_coefs();
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: extremes, retune extremes
    pending_items.push_back(sample_item(16'sh7FFF));
    pending_items.push_back(sample_item(-16'sh8000));
    pending_items.push_back(sample_item(16'sh7FFF));
    pending_items.push_back(sample_item(16'sh7FFF));
    pending_items.push_back(sample_item(-16'sh8000));
    pending_items.push_back(sample_item(-16'sh8000));
    pending_items.push_back(sample_item(0));
    pending_items.push_back(retune_item(32'd0));
    pending_items.push_back(sample_item(16'sh1234));
    pending_items.push_back(retune_item(32'hFFFF_FFFF));
    pending_items.push_back(sample_item(-16'sh8000));
    pending_items.push_back(sample_item(16'sh7FFF));
    pending_items.push_back(retune_item(32'h5555_AAAA));
    pending_items.push_back(retune_item(32'd80425));
    pending_items.push_back(sample_item(16'sh5555));
    pending_items.push_back(sample_item(-16'sh5556));
    drain();

    // long receiver hold-off while the sender keeps offering
    calm = 1;
    random_block(40, 1);
    hold_req = 1'b1;
    drain();
    calm = 0;
    random_block(500, 1);
    drain();

    // zero sample period: b = 1, mid = -2, a2 = 1
    reg_write(ADDR_TS, 32'd0);
    random_block(100, 0);
    drain();
    reg_write(ADDR_TS, 32'hFFFF_FFFF);
    reg_write(ADDR_WB, 32'hFFFF_FFFF);
    reg_write(ADDR_W0, 32'hFFFF_FFFF);
    random_block(200, 1);
    drain();
    reg_write(ADDR_TS, 32'd1);
    reg_write(ADDR_WB, 32'd0);
    reg_write(ADDR_W0, 32'd0);
    random_block(200, 1);
    drain();
    reg_write(ADDR_TS, $urandom_range(2000000, 100000));
    reg_write(ADDR_WB, $urandom_range(100000, 1000));
    reg_write(ADDR_W0, $urandom_range(200000, 10000));
    random_block(770, 1);
    drain();

    $display("covered %0d samples (%0d clipped), %0d retunes, register writes at extremes",
             n_samples, n_clipped, n_retunes);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
